// ----- rtl/core/hrce_pkg.sv -----
package hrce_pkg;

    // Number of key code slots in one keyboard report
    localparam int KeySlots = 6;
    // Width of the packed key slot field
    localparam int SlotFieldW = 48;
    // Key slot bytes past the field read as zero
    localparam int SlotExtW = (KeySlots * 8 > SlotFieldW) ? KeySlots * 8 : SlotFieldW;

    localparam int ModCount  = 8;
    localparam int ButtonCount = 5;
    // Event positions: modifiers, then presses, then releases
    localparam int PressBase   = ModCount;
    localparam int ReleaseBase = ModCount + KeySlots;
    localparam int MotionPos   = ButtonCount;
    localparam int ScrollPos   = ButtonCount + 1;
    localparam int MouseEv     = ButtonCount + 2;
    localparam int KeyEv       = ModCount + 2 * KeySlots;
    localparam int NumEv       = (KeyEv > MouseEv) ? KeyEv : MouseEv;
    localparam int IdxW        = $clog2(NumEv);

    localparam logic [15:0] KeyboardPage = 16'h0007;
    localparam logic [15:0] ModBase      = 16'h00E0;
    localparam logic [15:0] DelayMax     = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_KEYBOARD = 2'd0,
        OP_MOUSE    = 2'd1,
        OP_CAPTURE  = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_MOTION = 2'd2,
        KIND_SCROLL = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        now_ms;
        logic [15:0]        page_code;
        logic [7:0]         modifier_bits;
        logic [47:0]        key_slots;
        logic signed [15:0] motion_x;
        logic signed [15:0] motion_y;
        logic signed [7:0]  wheel_x;
        logic signed [7:0]  wheel_y;
    } item_t;

    typedef struct packed {
        logic [7:0]                    modifiers;
        logic [KeySlots-1:0][7:0]      keys;
        logic [7:0]                    buttons;
        logic [31:0]                   time_ms;
    } state_t;

    typedef struct packed {
        logic [NumEv-1:0]              mask;
        logic [NumEv-1:0][1:0]         kind;
        logic [NumEv-1:0][15:0]        val_a;
        logic [NumEv-1:0][15:0]        val_b;
        logic [15:0]                   delay;
    } event_set_t;

endpackage

// ----- rtl/core/hrce_detect.sv -----
module hrce_detect
(
    input  hrce_pkg::item_t      item,
    input  hrce_pkg::state_t     state_cur,
    input  logic                 capture_enable,
    output hrce_pkg::event_set_t events,
    output hrce_pkg::state_t     state_new,
    output logic                 state_we
);

    logic [hrce_pkg::SlotExtW-1:0]           slots_ext;
    logic [hrce_pkg::KeySlots-1:0][7:0]      cur;
    logic [31:0]                             diff;
    logic [15:0]                             delay;
    logic                                    is_kbd;
    logic                                    is_mouse;
    logic                                    found;

    assign slots_ext = hrce_pkg::SlotExtW'(item.key_slots);
    assign diff      = item.now_ms - state_cur.time_ms;
    // Saturate elapsed time
    assign delay     = (|diff[31:16]) ? hrce_pkg::DelayMax : diff[15:0];

    assign is_kbd   = capture_enable && (item.op == hrce_pkg::OP_KEYBOARD)
                      && (item.page_code == hrce_pkg::KeyboardPage);
    assign is_mouse = capture_enable && (item.op == hrce_pkg::OP_MOUSE);

    always_comb
    begin
        for (int i = 0; i < hrce_pkg::KeySlots; i++)
        begin
            cur[i] = slots_ext[8*i +: 8];
        end
    end

    always_comb
    begin
        events       = '0;
        events.delay = delay;
        state_new    = state_cur;
        state_we     = 1'b0;
        found        = 1'b0;
        unique case (hrce_pkg::op_t'(item.op))
            hrce_pkg::OP_CAPTURE:
            begin
                state_new.time_ms = item.now_ms;
                state_we          = 1'b1;
            end
            hrce_pkg::OP_KEYBOARD:
            begin
                if (is_kbd)
                begin
                    state_we            = 1'b1;
                    state_new.time_ms   = item.now_ms;
                    state_new.modifiers = item.modifier_bits;
                    state_new.keys      = cur;
                    for (int i = 0; i < hrce_pkg::ModCount; i++)
                    begin
                        events.mask[i]  = item.modifier_bits[i] ^ state_cur.modifiers[i];
                        events.kind[i]  = hrce_pkg::KIND_KEY;
                        events.val_a[i] = hrce_pkg::ModBase + 16'(i);
                        events.val_b[i] = 16'(item.modifier_bits[i]);
                    end
                    // Newly present keys
                    for (int i = 0; i < hrce_pkg::KeySlots; i++)
                    begin
                        found = 1'b0;
                        for (int j = 0; j < hrce_pkg::KeySlots; j++)
                        begin
                            found = found | (state_cur.keys[j] == cur[i]);
                        end
                        events.mask[hrce_pkg::PressBase+i]  = (cur[i] != 8'd0) && !found;
                        events.kind[hrce_pkg::PressBase+i]  = hrce_pkg::KIND_KEY;
                        events.val_a[hrce_pkg::PressBase+i] = 16'(cur[i]);
                        events.val_b[hrce_pkg::PressBase+i] = 16'd1;
                    end
                    // Keys no longer present
                    for (int i = 0; i < hrce_pkg::KeySlots; i++)
                    begin
                        found = 1'b0;
                        for (int j = 0; j < hrce_pkg::KeySlots; j++)
                        begin
                            found = found | (cur[j] == state_cur.keys[i]);
                        end
                        events.mask[hrce_pkg::ReleaseBase+i]  =
                            (state_cur.keys[i] != 8'd0) && !found;
                        events.kind[hrce_pkg::ReleaseBase+i]  = hrce_pkg::KIND_KEY;
                        events.val_a[hrce_pkg::ReleaseBase+i] = 16'(state_cur.keys[i]);
                        events.val_b[hrce_pkg::ReleaseBase+i] = 16'd0;
                    end
                end
            end
            hrce_pkg::OP_MOUSE:
            begin
                if (is_mouse)
                begin
                    state_we          = 1'b1;
                    state_new.time_ms = item.now_ms;
                    state_new.buttons = item.modifier_bits;
                    for (int i = 0; i < hrce_pkg::ButtonCount; i++)
                    begin
                        events.mask[i]  = item.modifier_bits[i] ^ state_cur.buttons[i];
                        events.kind[i]  = hrce_pkg::KIND_BUTTON;
                        events.val_a[i] = 16'(i + 1);
                        events.val_b[i] = 16'(item.modifier_bits[i]);
                    end
                    events.mask[hrce_pkg::MotionPos]  =
                        (item.motion_x != 16'sd0) || (item.motion_y != 16'sd0);
                    events.kind[hrce_pkg::MotionPos]  = hrce_pkg::KIND_MOTION;
                    events.val_a[hrce_pkg::MotionPos] = item.motion_x;
                    events.val_b[hrce_pkg::MotionPos] = item.motion_y;
                    events.mask[hrce_pkg::ScrollPos]  =
                        (item.wheel_x != 8'sd0) || (item.wheel_y != 8'sd0);
                    events.kind[hrce_pkg::ScrollPos]  = hrce_pkg::KIND_SCROLL;
                    events.val_a[hrce_pkg::ScrollPos] = 16'(item.wheel_x);
                    events.val_b[hrce_pkg::ScrollPos] = 16'(item.wheel_y);
                end
            end
            hrce_pkg::OP_UNUSED:
            begin
                state_we = 1'b0;
            end
            default:
            begin
                state_we = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/hid_report_change_events_top.sv -----
// Channel   Dir  Handshake            Payload
// input     in   in_valid/in_ready    op now_ms page_code modifier_bits key_slots
//                                     motion_x motion_y wheel_x wheel_y
// result    out  out_valid/out_ready  event_kind gap_ms value_a value_b last_event
// config    in   APB psel/penable     capture_enable at byte address 0
//
// Three register stages: input register, event register, result register.
// A report is compared against stored state as it enters the event register; events
// then leave one per cycle while the result register is free or being read, so a
// report with N events occupies the event register until its last event moves on,
// and a report with no events leaves the event register empty.
// rst_n clears all control and stored state asynchronously; capture starts disabled.
// A stalled result holds the result register; the event register and input register
// keep filling until both hold an item, then in_ready drops.
module hid_report_change_events_top
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [31:0]        now_ms,
    input  logic [15:0]        page_code,
    input  logic [7:0]         modifier_bits,
    input  logic [47:0]        key_slots,
    input  logic signed [15:0] motion_x,
    input  logic signed [15:0] motion_y,
    input  logic signed [7:0]  wheel_x,
    input  logic signed [7:0]  wheel_y,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         event_kind,
    output logic [15:0]        gap_ms,
    output logic signed [15:0] value_a,
    output logic signed [15:0] value_b,
    output logic               last_event
);

    // Configuration
    logic capture_enable_reg;
    logic cfg_write;

    // Input register
    logic              in_valid_reg;
    hrce_pkg::item_t   item_reg;
    hrce_pkg::item_t   item_in;

    // Stored report state
    hrce_pkg::state_t  state_reg;
    hrce_pkg::state_t  state_new;
    logic              state_we;

    // Event register
    hrce_pkg::event_set_t events;
    logic [hrce_pkg::NumEv-1:0]        mask_reg;
    logic [hrce_pkg::NumEv-1:0]        mask_next;
    logic [hrce_pkg::NumEv-1:0][1:0]   kind_reg;
    logic [hrce_pkg::NumEv-1:0][15:0]  val_a_reg;
    logic [hrce_pkg::NumEv-1:0][15:0]  val_b_reg;
    logic [15:0]                       delay_reg;
    logic                              first_reg;
    logic                              first_next;
    logic [hrce_pkg::NumEv-1:0]        pick;
    logic [hrce_pkg::NumEv-1:0]        mask_rest;
    logic [hrce_pkg::IdxW-1:0]         pick_idx;

    // Result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  kind_out_reg;
    logic [15:0] delay_out_reg;
    logic [15:0] a_out_reg;
    logic [15:0] b_out_reg;
    logic        last_out_reg;

    // Flow control
    logic work_free;
    logic eval_fire;
    logic emit_fire;
    logic out_open;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, capture_enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            capture_enable_reg <= pwdata[0];
        end
    end

    // ---------------------------------------------------------------- input register
    assign item_in.op            = op;
    assign item_in.now_ms        = now_ms;
    assign item_in.page_code     = page_code;
    assign item_in.modifier_bits = modifier_bits;
    assign item_in.key_slots     = key_slots;
    assign item_in.motion_x      = motion_x;
    assign item_in.motion_y      = motion_y;
    assign item_in.wheel_x       = wheel_x;
    assign item_in.wheel_y       = wheel_y;

    // Take a new transfer while the input register is empty or its held item moves on this cycle
    assign in_ready = !in_valid_reg || eval_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    // ---------------------------------------------------------------- compare
    hrce_detect u_detect
    (
        .item           (item_reg),
        .state_cur      (state_reg),
        .capture_enable (capture_enable_reg),
        .events         (events),
        .state_new      (state_new),
        .state_we       (state_we)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (eval_fire && state_we)
        begin
            state_reg <= state_new;
        end
    end

    // ---------------------------------------------------------------- event register
    // Lowest pending event goes out first, which keeps report order
    assign pick      = mask_reg & (~mask_reg + hrce_pkg::NumEv'(1));
    assign mask_rest = mask_reg & ~pick;

    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < hrce_pkg::NumEv; i++)
        begin
            if (pick[i])
            begin
                pick_idx = hrce_pkg::IdxW'(i);
            end
        end
    end

    assign out_open  = !out_valid_reg || out_ready;
    assign emit_fire = (mask_reg != '0) && out_open;
    // Event register is free when empty or as its final event moves to the result register
    assign work_free = (mask_reg == '0) || (emit_fire && (mask_rest == '0));
    assign eval_fire = in_valid_reg && work_free;

    always_comb
    begin
        mask_next  = mask_reg;
        first_next = first_reg;
        priority if (eval_fire)
        begin
            mask_next  = events.mask;
            first_next = 1'b1;
        end
        else if (emit_fire)
        begin
            mask_next  = mask_rest;
            first_next = 1'b0;
        end
        else
        begin
            mask_next  = mask_reg;
            first_next = first_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_fire)
        begin
            kind_reg  <= events.kind;
            val_a_reg <= events.val_a;
            val_b_reg <= events.val_b;
            delay_reg <= events.delay;
        end
    end

    // ---------------------------------------------------------------- result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Only the first event of a report carries the elapsed time
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            kind_out_reg  <= kind_reg[pick_idx];
            delay_out_reg <= first_reg ? delay_reg : 16'd0;
            a_out_reg     <= val_a_reg[pick_idx];
            b_out_reg     <= val_b_reg[pick_idx];
            last_out_reg  <= (mask_rest == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_out_reg;
    assign gap_ms     = delay_out_reg;
    assign value_a    = a_out_reg;
    assign value_b    = b_out_reg;
    assign last_event = last_out_reg;

    // ---------------------------------------------------------------- assertions
    // A later event of the same report never carries a delay
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && !first_reg) |=> (delay_out_reg == 16'd0))
        else $error("non-first event carries a delay");

    // After the final event leaves, either the register is empty or a fresh report starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && (mask_rest == '0)) |=> ((mask_reg == '0) || first_reg))
        else $error("event register left in a stale state");

    // A shown event that is not the last one must leave more events pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_out_reg) |-> (mask_reg != '0))
        else $error("report ended without a last event");

    // The input register only advances while the event register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !work_free) |=> (in_valid_reg && $stable(item_reg)))
        else $error("held item lost while event register busy");

endmodule

// ----- tb/sv/hid_report_change_events_top_tb.sv -----
`timescale 1ns / 1ps

module hid_report_change_events_top_tb;
    import hrce_pkg::*;

    // Register map: capture_enable is the only register
    localparam int          RegCaptureEnable  = 0;
    localparam logic [2:0]  CaptureEnableAddr = 3'(4 * RegCaptureEnable);

    // Cycles to hold off after the last result before touching the register,
    // covering a report that is still in flight but produces nothing
    localparam int SettleCycles = 8;
    // Cycles without any transfer before the run is declared hung
    localparam int StallLimit   = 3000;
    localparam int ShownErrors  = 10;

    localparam int PlanRows     = 24;
    localparam int DisabledRows = 3;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic [31:0]        now_ms;
    logic [15:0]        page_code;
    logic [7:0]         modifier_bits;
    logic [47:0]        key_slots;
    logic signed [15:0] motion_x;
    logic signed [15:0] motion_y;
    logic signed [7:0]  wheel_x;
    logic signed [7:0]  wheel_y;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         event_kind;
    logic [15:0]        gap_ms;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic               last_event;

    hid_report_change_events_top DUT (.*);

    // One change event as it should leave the block
    typedef struct packed {
        kind_t       kind;
        logic [15:0] delay;
        logic [15:0] val_a;
        logic [15:0] val_b;
        logic        last;
    } change_t;

    // Directed row: one report plus, where it is obvious, its single outcome.
    // chk < 0 means the predictor decides; 0 or 1 is the typed-in event count.
    typedef struct {
        op_t         op;
        logic [31:0] now;
        logic [15:0] page;
        logic [7:0]  bits;
        logic [47:0] slots;
        logic [15:0] mx;
        logic [15:0] my;
        logic [7:0]  wx;
        logic [7:0]  wy;
        int          chk;
        kind_t       kind;
        logic [15:0] delay;
        logic [15:0] val_a;
        logic [15:0] val_b;
    } plan_row_t;

    plan_row_t plan [PlanRows] = '{
        // capture off: reports leave no trace at all
        '{OP_KEYBOARD, 32'd100, 16'h0007, 8'hFF, 48'h04, 16'h0000, 16'h0000, 8'h00, 8'h00,
          0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        '{OP_MOUSE, 32'd200, 16'h0000, 8'h1F, 48'h0, 16'h0005, 16'h0000, 8'h00, 8'h00,
          0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        // capture start marks the time even while capture is off
        '{OP_CAPTURE, 32'd1000, 16'h0000, 8'h00, 48'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
          0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        // capture on from here: first key press after the mark
        '{OP_KEYBOARD, 32'd1010, 16'h0007, 8'h00, 48'h04, 16'h0000, 16'h0000, 8'h00, 8'h00,
          1, KIND_KEY, 16'd10, 16'h0004, 16'h0001},
        // foreign usage page and the unused op are dropped, time untouched
        '{OP_KEYBOARD, 32'd1500, 16'h000C, 8'hFF, 48'hFFFF_FFFF_FFFF, 16'h0000, 16'h0000,
          8'h00, 8'h00, 0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        '{OP_UNUSED, 32'd1600, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF,
          8'hFF, 8'hFF, 0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        // unchanged report: nothing out, but the time mark moves
        '{OP_KEYBOARD, 32'd1020, 16'h0007, 8'h00, 48'h04, 16'h0000, 16'h0000, 8'h00, 8'h00,
          0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        // long gap saturates the delay
        '{OP_KEYBOARD, 32'd101020, 16'h0007, 8'h00, 48'h0504, 16'h0000, 16'h0000, 8'h00, 8'h00,
          1, KIND_KEY, 16'hFFFF, 16'h0005, 16'h0001},
        '{OP_KEYBOARD, 32'd101021, 16'h0007, 8'h00, 48'h0404, 16'h0000, 16'h0000, 8'h00, 8'h00,
          1, KIND_KEY, 16'd1, 16'h0005, 16'h0000},
        // six fresh keys, duplicated old key released twice
        '{OP_KEYBOARD, 32'd101030, 16'h0007, 8'h00, 48'h0A0B_0C0D_0E0F, 16'h0000, 16'h0000,
          8'h00, 8'h00, -1, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        // worst case: every modifier, six presses, six releases
        '{OP_KEYBOARD, 32'd101040, 16'h0007, 8'hFF, 48'hFFFE_FDFC_FBFA, 16'h0000, 16'h0000,
          8'h00, 8'h00, -1, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        '{OP_KEYBOARD, 32'd101041, 16'h0007, 8'h00, 48'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
          -1, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        // same code in two slots gives two presses
        '{OP_KEYBOARD, 32'd101042, 16'h0007, 8'hA5, 48'h0707, 16'h0000, 16'h0000, 8'h00, 8'h00,
          -1, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        // time wraps between the mark and the next report
        '{OP_CAPTURE, 32'hFFFF_FFF0, 16'h0000, 8'h00, 48'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
          0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        '{OP_KEYBOARD, 32'd5, 16'h0007, 8'hA5, 48'h0807, 16'h0000, 16'h0000, 8'h00, 8'h00,
          1, KIND_KEY, 16'd21, 16'h0008, 16'h0001},
        // mouse extremes: all buttons, full-scale motion and scroll
        '{OP_MOUSE, 32'hFFFF_FFFF, 16'h0000, 8'h1F, 48'h0, 16'h8000, 16'h7FFF, 8'h80, 8'h7F,
          -1, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        '{OP_MOUSE, 32'hFFFF_FFFF, 16'h0000, 8'hE0, 48'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
          -1, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        // only the upper button bits change: not compared
        '{OP_MOUSE, 32'd0, 16'h0000, 8'h00, 48'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
          0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        '{OP_MOUSE, 32'd3, 16'h0000, 8'h00, 48'h0, 16'h0000, 16'hFFFF, 8'h00, 8'h00,
          1, KIND_MOTION, 16'd3, 16'h0000, 16'hFFFF},
        '{OP_MOUSE, 32'd7, 16'h0000, 8'h00, 48'h0, 16'h0000, 16'h0000, 8'h00, 8'hFF,
          1, KIND_SCROLL, 16'd4, 16'h0000, 16'hFFFF},
        '{OP_MOUSE, 32'd8, 16'h0000, 8'h04, 48'h0, 16'h7FFF, 16'h8000, 8'h7F, 8'h80,
          -1, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        '{OP_KEYBOARD, 32'd9, 16'hFFFF, 8'h00, 48'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
          0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        '{OP_KEYBOARD, 32'd10, 16'h0000, 8'h00, 48'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
          0, KIND_KEY, 16'd0, 16'h0000, 16'h0000},
        '{OP_UNUSED, 32'd0, 16'h0000, 8'h00, 48'h0, 16'h0000, 16'h0000, 8'h00, 8'h00,
          0, KIND_KEY, 16'd0, 16'h0000, 16'h0000}
    };

    // Predictor state, mirrors what the block keeps between reports
    logic        capture_on;
    logic [7:0]  held_mods;
    logic [7:0]  held_keys [KeySlots];
    logic [7:0]  held_buttons;
    logic [31:0] mark_ms;

    // Stimulus shaping state: keeps random reports close to real typing
    logic [31:0] clock_ms;
    logic [7:0]  kb_mods_drv;
    logic [47:0] kb_slots_drv;
    logic [7:0]  btn_drv;

    bit      idle_on;
    bit      stalls_on;
    int      mismatch_count;
    change_t report_changes [$];
    change_t pending_changes [$];
    change_t head_change;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= ShownErrors)
            $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    function automatic change_t make_change(input kind_t kind, input logic [15:0] a,
                                            input logic [15:0] b);
        change_t c;
        c.kind  = kind;
        c.delay = '0;
        c.val_a = a;
        c.val_b = b;
        c.last  = 1'b0;
        return c;
    endfunction

    // Elapsed time since the last handled report, saturated; moves the mark
    function automatic logic [15:0] elapsed_ms(input logic [31:0] now);
        logic [31:0] span;
        span    = now - mark_ms;
        mark_ms = now;
        return (span > {16'd0, DelayMax}) ? DelayMax : span[15:0];
    endfunction

    // Work out the change events of one report into report_changes
    task automatic derive_changes(input item_t it);
        logic [SlotExtW-1:0] wide;
        logic [7:0]          cur [KeySlots];
        logic [15:0]         gap;
        bit                  hit;
        report_changes.delete();
        if (it.op == OP_CAPTURE)
        begin
            mark_ms = it.now_ms;
            return;
        end
        if (it.op == OP_UNUSED || !capture_on)
            return;
        if (it.op == OP_KEYBOARD && it.page_code != KeyboardPage)
            return;
        gap = elapsed_ms(it.now_ms);
        if (it.op == OP_KEYBOARD)
        begin
            wide = SlotExtW'(it.key_slots);
            for (int i = 0; i < KeySlots; i++)
                cur[i] = wide[8*i +: 8];
            for (int i = 0; i < ModCount; i++)
                if (held_mods[i] != it.modifier_bits[i])
                    report_changes.push_back(make_change(KIND_KEY, ModBase + 16'(i),
                                                         {15'd0, it.modifier_bits[i]}));
            held_mods = it.modifier_bits;
            // presses: codes not seen anywhere in the previous report
            for (int i = 0; i < KeySlots; i++)
            begin
                hit = 1'b0;
                for (int j = 0; j < KeySlots; j++)
                    if (held_keys[j] == cur[i])
                        hit = 1'b1;
                if (cur[i] != 8'd0 && !hit)
                    report_changes.push_back(make_change(KIND_KEY, {8'd0, cur[i]}, 16'd1));
            end
            // releases: old codes missing from this report
            for (int i = 0; i < KeySlots; i++)
            begin
                hit = 1'b0;
                for (int j = 0; j < KeySlots; j++)
                    if (cur[j] == held_keys[i])
                        hit = 1'b1;
                if (held_keys[i] != 8'd0 && !hit)
                    report_changes.push_back(make_change(KIND_KEY, {8'd0, held_keys[i]},
                                                         16'd0));
            end
            held_keys = cur;
        end
        else
        begin
            for (int i = 0; i < ButtonCount; i++)
                if (held_buttons[i] != it.modifier_bits[i])
                    report_changes.push_back(make_change(KIND_BUTTON, 16'(i + 1),
                                                         {15'd0, it.modifier_bits[i]}));
            held_buttons = it.modifier_bits;
            if (it.motion_x != 16'sd0 || it.motion_y != 16'sd0)
                report_changes.push_back(make_change(KIND_MOTION, it.motion_x, it.motion_y));
            if (it.wheel_x != 8'sd0 || it.wheel_y != 8'sd0)
                report_changes.push_back(make_change(KIND_SCROLL,
                                                     {{8{it.wheel_x[7]}}, it.wheel_x},
                                                     {{8{it.wheel_y[7]}}, it.wheel_y}));
        end
        if (report_changes.size() > 0)
        begin
            report_changes[0].delay = gap;
            report_changes[report_changes.size() - 1].last = 1'b1;
        end
    endtask

    // Drive one report, hold it until the transfer, then queue its events.
    // typed_count < 0 takes the predictor's events, else the typed-in outcome.
    task automatic send_report(input item_t it, input int typed_count, input change_t typed);
        in_valid      <= 1'b1;
        op            <= it.op;
        now_ms        <= it.now_ms;
        page_code     <= it.page_code;
        modifier_bits <= it.modifier_bits;
        key_slots     <= it.key_slots;
        motion_x      <= it.motion_x;
        motion_y      <= it.motion_y;
        wheel_x       <= it.wheel_x;
        wheel_y       <= it.wheel_y;
        do @(posedge clk); while (!in_ready);
        derive_changes(it);
        if (typed_count < 0)
        begin
            foreach (report_changes[i])
                pending_changes.push_back(report_changes[i]);
        end
        else if (typed_count == 1)
            pending_changes.push_back(typed);
    endtask

    // Random sender gap: while idle_on, now and then drop valid before the next report
    task automatic maybe_pause();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every outstanding event, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_changes.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Write capture_enable, then read it back in the next APB transfer
    task automatic program_capture(input logic [31:0] value);
        logic [31:0] back;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CaptureEnableAddr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        capture_on = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        back = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (back[0] !== value[0])
            log_mismatch($sformatf("capture_enable read %0b, wrote %0b", back[0], value[0]));
    endtask

    // Mostly well-formed reports that keep state across items, plus noise
    function automatic item_t random_report();
        item_t       it;
        int unsigned pick;
        pick             = $urandom_range(0, 99);
        it.op            = OP_KEYBOARD;
        it.page_code     = KeyboardPage;
        it.modifier_bits = 8'($urandom);
        it.key_slots     = {16'($urandom), $urandom};
        it.motion_x      = 16'($urandom);
        it.motion_y      = 16'($urandom);
        it.wheel_x       = 8'($urandom);
        it.wheel_y       = 8'($urandom);
        case ($urandom_range(0, 29))
            0:       clock_ms = $urandom;
            1, 2:    clock_ms += 32'($urandom_range(65536, 300000));
            default: clock_ms += 32'($urandom_range(0, 40));
        endcase
        it.now_ms = clock_ms;
        if (pick < 55)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                // typing: flip the odd modifier, swap keys from a small pool
                for (int i = 0; i < ModCount; i++)
                    if ($urandom_range(0, 9) == 0)
                        kb_mods_drv[i] = ~kb_mods_drv[i];
                for (int i = 0; i < SlotFieldW / 8; i++)
                    if ($urandom_range(0, 3) == 0)
                        kb_slots_drv[8*i +: 8] = ($urandom_range(0, 2) == 0) ?
                                                 8'd0 : 8'($urandom_range(4, 14));
            end
            else
            begin
                kb_mods_drv  = it.modifier_bits;
                kb_slots_drv = it.key_slots;
            end
            it.modifier_bits = kb_mods_drv;
            it.key_slots     = kb_slots_drv;
        end
        else if (pick < 85)
        begin
            it.op = OP_MOUSE;
            for (int i = 0; i < 8; i++)
                if ($urandom_range(0, 5) == 0)
                    btn_drv[i] = ~btn_drv[i];
            it.modifier_bits = btn_drv;
            case ($urandom_range(0, 5))
                0:
                begin
                    it.motion_x = 16'sd0;
                    it.motion_y = 16'sd0;
                end
                1:
                begin
                end
                default:
                begin
                    it.motion_x = 16'($urandom_range(0, 40)) - 16'd20;
                    it.motion_y = ($urandom_range(0, 2) == 0) ?
                                  16'sd0 : 16'($urandom_range(0, 40)) - 16'd20;
                end
            endcase
            case ($urandom_range(0, 5))
                0:
                begin
                end
                1, 2:
                begin
                    it.wheel_x = ($urandom_range(0, 1) == 0) ?
                                 8'sd0 : 8'($urandom_range(0, 6)) - 8'd3;
                    it.wheel_y = 8'($urandom_range(0, 6)) - 8'd3;
                end
                default:
                begin
                    it.wheel_x = 8'sd0;
                    it.wheel_y = 8'sd0;
                end
            endcase
        end
        else if (pick < 90)
            it.op = OP_CAPTURE;
        else if (pick < 95)
        begin
            it.page_code = 16'($urandom);
            if (it.page_code == KeyboardPage)
                it.page_code = 16'hFFFF;
        end
        else
            it.op = OP_UNUSED;
        return it;
    endfunction

    // Receiver: long ready runs broken by stall bursts while stalls_on is set
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(60, 150)) @(posedge clk);
            else
                repeat ($urandom_range(1, 24)) @(posedge clk);
            if (stalls_on)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Check every result transfer against the oldest pending event
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_changes.size() == 0)
                log_mismatch($sformatf("unexpected event kind=%0d delay=%0d a=%0d b=%0d last=%0b",
                                       event_kind, gap_ms, value_a, value_b, last_event));
            else
            begin
                head_change = pending_changes.pop_front();
                if (event_kind !== head_change.kind || gap_ms !== head_change.delay ||
                    value_a !== head_change.val_a || value_b !== head_change.val_b ||
                    last_event !== head_change.last)
                    log_mismatch($sformatf({"expected kind=%0d delay=%0d a=%0d b=%0d last=%0b",
                                            ", got kind=%0d delay=%0d a=%0d b=%0d last=%0b"},
                                           head_change.kind, head_change.delay,
                                           $signed(head_change.val_a),
                                           $signed(head_change.val_b), head_change.last,
                                           event_kind, gap_ms, value_a, value_b,
                                           last_event));
            end
        end
    end

    // Watchdog: give up after too many cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < StallLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[hid_report_change_events_top] ERROR");
        $finish;
    end

    initial
    begin
        item_t   row_item;
        change_t typed;

        // Hold every input at a known value from time zero
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        op            <= '0;
        now_ms        <= '0;
        page_code     <= '0;
        modifier_bits <= '0;
        key_slots     <= '0;
        motion_x      <= '0;
        motion_y      <= '0;
        wheel_x       <= '0;
        wheel_y       <= '0;

        capture_on     = 1'b0;
        held_mods      = '0;
        held_buttons   = '0;
        mark_ms        = '0;
        foreach (held_keys[i])
            held_keys[i] = '0;
        kb_mods_drv    = '0;
        kb_slots_drv   = '0;
        btn_drv        = '0;
        idle_on        = 1'b1;
        stalls_on      = 1'b1;
        mismatch_count = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        program_capture(32'd0);

        // Directed table; capture goes on after the first three rows
        for (int k = 0; k < PlanRows; k++)
        begin
            if (k == DisabledRows)
            begin
                settle();
                program_capture(32'd1);
            end
            row_item.op            = plan[k].op;
            row_item.now_ms        = plan[k].now;
            row_item.page_code     = plan[k].page;
            row_item.modifier_bits = plan[k].bits;
            row_item.key_slots     = plan[k].slots;
            row_item.motion_x      = plan[k].mx;
            row_item.motion_y      = plan[k].my;
            row_item.wheel_x       = plan[k].wx;
            row_item.wheel_y       = plan[k].wy;
            typed       = make_change(plan[k].kind, plan[k].val_a, plan[k].val_b);
            typed.delay = plan[k].delay;
            typed.last  = 1'b1;
            maybe_pause();
            send_report(row_item, plan[k].chk, typed);
        end

        // Random traffic with capture on; now and then drain completely
        clock_ms = 32'd20;
        typed    = make_change(KIND_KEY, 16'd0, 16'd0);
        for (int k = 0; k < 136; k++)
        begin
            maybe_pause();
            send_report(random_report(), -1, typed);
            if ($urandom_range(0, 39) == 0)
                settle();
        end

        // Capture off: reports must vanish and leave no state behind, but capture marks still move the time
        settle();
        program_capture(32'd0);
        for (int k = 0; k < 30; k++)
        begin
            maybe_pause();
            send_report(random_report(), -1, typed);
        end

        // Capture back on through a write with all data bits set
        settle();
        program_capture(32'hFFFF_FFFF);
        for (int k = 0; k < 130; k++)
        begin
            maybe_pause();
            send_report(random_report(), -1, typed);
        end

        // Closing stretch at full rate on both sides
        idle_on   = 1'b0;
        stalls_on = 1'b0;
        for (int k = 0; k < 60; k++)
            send_report(random_report(), -1, typed);

        in_valid <= 1'b0;
        while (pending_changes.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);

        if (mismatch_count == 0 && pending_changes.size() == 0)
            $display("[hid_report_change_events_top] OK");
        else
            $display("[hid_report_change_events_top] ERROR");
        $finish;
    end

endmodule
